>>> rtl/rse_pkg.sv
// Shared types and constants for the RPN stack evaluator.
`default_nettype none

package rse_pkg;

  localparam int DATA_W  = 32;
  localparam int DEPTH_W = 7;

  typedef enum logic [2:0] {
    ACT_PUSH  = 3'd0,
    ACT_ADD   = 3'd1,
    ACT_SUB   = 3'd2,
    ACT_MUL   = 3'd3,
    ACT_DIV   = 3'd4,
    ACT_MOD   = 3'd5,
    ACT_PRINT = 3'd6,
    ACT_STOP  = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    ST_PRINTED   = 3'd0,
    ST_STOPPED   = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_DIVZERO   = 3'd4
  } status_t;

  typedef struct packed {
    action_t                    action;
    logic signed [DATA_W-1:0]   operand_value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]   result_value;
    logic [DEPTH_W-1:0]         final_depth;
    status_t                    status;
  } rsp_t;

  typedef struct packed {
    logic    latch;
    logic    push;
    logic    exec;
    logic    write;
    logic    emit;
    logic    pop;
    logic    clear;
    logic    refill;
    status_t code;
  } ctrl_cmd_t;

  typedef struct packed {
    action_t action;
    logic    empty;
    logic    lt2;
    logic    full;
    logic    b_zero;
    logic    div_done;
    logic    out_free;
  } ctrl_stat_t;

endpackage

`default_nettype wire

>>> rtl/rse_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none

module rse_div
  import rse_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] dividend,
  input  wire logic [DATA_W-1:0] divisor,
  output logic                   done,
  output logic [DATA_W-1:0]      quotient,
  output logic [DATA_W-1:0]      remainder
);

  localparam int CNT_W = $clog2(DATA_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dvd;
  logic [DATA_W-1:0] dvs;
  logic              neg_q;
  logic              neg_r;
  logic [DATA_W:0]   trial;

  assign trial = {rem, dvd[DATA_W-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      dvd   <= dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
      dvs   <= divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
      neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
      neg_r <= dividend[DATA_W-1];
    end else if (busy) begin
      if (!trial[DATA_W]) begin
        rem <= trial[DATA_W-1:0];
        dvd <= {dvd[DATA_W-2:0], 1'b1};
      end else begin
        rem <= {rem[DATA_W-2:0], dvd[DATA_W-1]};
        dvd <= {dvd[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign quotient  = neg_q ? (~dvd + 1'b1) : dvd;
  assign remainder = neg_r ? (~rem + 1'b1) : rem;

endmodule

`default_nettype wire

>>> rtl/rse_datapath.sv
// Stack memory, top-of-stack register, ALU, divider and response register.
`default_nettype none

module rse_datapath
  import rse_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire req_t       cmd,
  input  wire ctrl_cmd_t  ctl,
  output ctrl_stat_t      stat,
  output logic            rsp_valid,
  input  wire logic       rsp_ready,
  output rsp_t            rsp
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW = $clog2(STACK_DEPTH + 1);

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] tos;
  logic [DATA_W-1:0] alu_res;
  logic [DATA_W-1:0] opnd;
  action_t           act;
  logic [DW-1:0]     depth;
  logic [DW-1:0]     depth_dec;
  logic [DW-1:0]     depth_m2;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              we;
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] quot;
  logic [DATA_W-1:0] remd;

  assign depth_dec = depth - DW'(1);
  assign depth_m2  = depth - DW'(2);
  assign rd_addr   = depth_m2[AW-1:0];
  assign we        = ctl.push | ctl.write;
  assign wr_addr   = ctl.push ? depth[AW-1:0] : rd_addr;
  assign wr_data   = ctl.push ? opnd : alu_res;
  assign div_start = ctl.exec & ((act == ACT_DIV) | (act == ACT_MOD));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      act  <= cmd.action;
      opnd <= cmd.operand_value;
    end
    if (ctl.exec) begin
      case (act)
        ACT_ADD: alu_res <= rd_data + tos;
        ACT_SUB: alu_res <= rd_data - tos;
        ACT_MUL: alu_res <= rd_data * tos;
        default: alu_res <= alu_res;
      endcase
    end else if (div_done) begin
      alu_res <= (act == ACT_MOD) ? remd : quot;
    end
    if (ctl.push) begin
      tos <= opnd;
    end else if (ctl.write) begin
      tos <= alu_res;
    end else if (ctl.refill) begin
      tos <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (ctl.push) begin
      depth <= depth + DW'(1);
    end else if (ctl.write || (ctl.emit && ctl.pop)) begin
      depth <= depth_dec;
    end else if (ctl.emit && ctl.clear) begin
      depth <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      rsp.status       <= ctl.code;
      rsp.result_value <= (ctl.code == ST_PRINTED) ? tos : '0;
      rsp.final_depth  <= (ctl.code == ST_PRINTED) ? DEPTH_W'(depth_dec) : DEPTH_W'(depth);
    end
  end

  rse_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (rd_data),
    .divisor   (tos),
    .done      (div_done),
    .quotient  (quot),
    .remainder (remd)
  );

  assign stat.action   = act;
  assign stat.empty    = (depth == '0);
  assign stat.lt2      = (depth < DW'(2));
  assign stat.full     = (depth == DW'(STACK_DEPTH));
  assign stat.b_zero   = (tos == '0);
  assign stat.div_done = div_done;
  assign stat.out_free = !rsp_valid || rsp_ready;

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DW'(STACK_DEPTH))
    else $error("stack depth above capacity");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> (!rsp_valid || rsp_ready))
    else $error("response overwritten while pending");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> depth != DW'(STACK_DEPTH))
    else $error("push into full stack");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (ctl.write || (ctl.emit && ctl.pop)) |-> depth != '0)
    else $error("pop from empty stack");

endmodule

`default_nettype wire

>>> rtl/rse_ctrl.sv
// Sequencing state machine for the RPN stack evaluator.
`default_nettype none

module rse_ctrl
  import rse_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cmd_valid,
  output logic            cmd_ready,
  input  wire ctrl_stat_t stat,
  output ctrl_cmd_t       ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_PUSH,
    S_EXEC,
    S_DIVWAIT,
    S_WRITE,
    S_EMIT,
    S_REFILL
  } state_t;

  state_t  state;
  state_t  state_next;
  status_t code;
  status_t code_next;

  always_comb begin
    state_next = state;
    code_next  = code;
    case (state)
      S_IDLE: begin
        if (cmd_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        state_next = S_EMIT;
        case (stat.action)
          ACT_PUSH: begin
            if (stat.full) code_next = ST_OVERFLOW;
            else state_next = S_PUSH;
          end
          ACT_PRINT: begin
            code_next = stat.empty ? ST_UNDERFLOW : ST_PRINTED;
          end
          ACT_STOP: begin
            code_next = ST_STOPPED;
          end
          default: begin
            if (stat.lt2) begin
              code_next = ST_UNDERFLOW;
            end else if ((stat.action inside {ACT_DIV, ACT_MOD}) && stat.b_zero) begin
              code_next = ST_DIVZERO;
            end else begin
              state_next = S_EXEC;
            end
          end
        endcase
      end
      S_PUSH:    state_next = S_IDLE;
      S_EXEC: begin
        state_next = (stat.action inside {ACT_DIV, ACT_MOD}) ? S_DIVWAIT : S_WRITE;
      end
      S_DIVWAIT: begin
        if (stat.div_done) state_next = S_WRITE;
      end
      S_WRITE:   state_next = S_IDLE;
      S_EMIT: begin
        if (stat.out_free) state_next = (code == ST_PRINTED) ? S_REFILL : S_IDLE;
      end
      S_REFILL:  state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= ST_PRINTED;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  assign cmd_ready = (state == S_IDLE);

  always_comb begin
    ctl        = '0;
    ctl.code   = code;
    ctl.latch  = (state == S_IDLE) && cmd_valid;
    ctl.push   = (state == S_PUSH);
    ctl.exec   = (state == S_EXEC);
    ctl.write  = (state == S_WRITE);
    ctl.emit   = (state == S_EMIT) && stat.out_free;
    ctl.pop    = (code == ST_PRINTED);
    ctl.clear  = (code == ST_STOPPED);
    ctl.refill = (state == S_REFILL);
  end

endmodule

`default_nettype wire

>>> rtl/rpn_stack_evaluator.sv
// Top level of the RPN stack evaluator: controller plus datapath.
`default_nettype none

// Reverse-Polish evaluator with a STACK_DEPTH-entry stack of 32-bit words. One
// request is processed at a time; a response waits for the response slot, and
// div and mod wait for the divider, which retires one quotient bit per cycle.
// The top of stack sits in a register and the rest in a one-write, one-read
// memory whose read data is registered. A response waits in an output
// register, so new requests are taken while it is still pending. Stack
// entries need no clearing after reset.
module rpn_stack_evaluator
  import rse_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_ready,
  input  wire req_t cmd,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  ctrl_cmd_t  ctl;
  ctrl_stat_t stat;

  rse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  rse_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ctl       (ctl),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the RPN stack evaluator: directed and random programs.
module tb;
  import rse_pkg::*;

  localparam int STACK_SLOTS  = 64;
  localparam int RANDOM_ITEMS = 1350;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 64;

  logic clk;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  req_t cmd = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  rpn_stack_evaluator #(.STACK_DEPTH(STACK_SLOTS)) u_top (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  logic [31:0] eval_stack [STACK_SLOTS];
  int          eval_depth = 0;
  rsp_t        expected_results [$];
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;
  bit          hold_request = 1'b0;

  // Updates the stack image; returns 1 when the request yields a response.
  function automatic bit predict_result(input req_t r, output rsp_t res);
    logic [31:0] a, b, q;
    longint sa, sb;
    res = '{result_value: '0, final_depth: 7'(eval_depth), status: ST_PRINTED};
    case (r.action)
      ACT_PUSH: begin
        if (eval_depth >= STACK_SLOTS) begin
          res.status = ST_OVERFLOW;
          return 1'b1;
        end
        eval_stack[eval_depth] = r.operand_value;
        eval_depth++;
        return 1'b0;
      end
      ACT_PRINT: begin
        if (eval_depth < 1) begin
          res.status = ST_UNDERFLOW;
          return 1'b1;
        end
        eval_depth--;
        res.result_value = eval_stack[eval_depth];
        res.final_depth  = 7'(eval_depth);
        return 1'b1;
      end
      ACT_STOP: begin
        res.status = ST_STOPPED;
        eval_depth = 0;
        return 1'b1;
      end
      default: ;
    endcase
    if (eval_depth < 2) begin
      res.status = ST_UNDERFLOW;
      return 1'b1;
    end
    b  = eval_stack[eval_depth-1];
    a  = eval_stack[eval_depth-2];
    sa = $signed(a);
    sb = $signed(b);
    case (r.action)
      ACT_ADD: q = a + b;
      ACT_SUB: q = a - b;
      ACT_MUL: q = a * b;
      ACT_DIV: begin
        if (b == 0) begin
          res.status = ST_DIVZERO;
          return 1'b1;
        end
        q = 32'(sa / sb);
      end
      default: begin
        if (b == 0) begin
          res.status = ST_DIVZERO;
          return 1'b1;
        end
        q = 32'(sa % sb);
      end
    endcase
    eval_depth--;
    eval_stack[eval_depth-1] = q;
    return 1'b0;
  endfunction

  task automatic send_request(input action_t act, input logic [31:0] val);
    req_t r;
    rsp_t want;
    int gap;
    r   = '{action: act, operand_value: val};
    gap = send_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= r;
    do @(posedge clk); while (cmd_ready !== 1'b1);
    if (predict_result(r, want))
      expected_results.push_back(want);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0;
      4, 5, 6: return $urandom_range(0, 16) - 8;
      default: return $urandom;
    endcase
  endfunction

  // Response side: random ready gaps, plus one long hold when requested.
  initial begin
    int gap;
    wait (!rst);
    forever begin
      if (hold_request) begin
        gap = HOLD_CYCLES;
        hold_request = 1'b0;
      end else begin
        gap = recv_idle ? $urandom_range(0, 11) : 0;
      end
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (rsp_valid !== 1'b1);
    end
  end

  function automatic void note_mismatch(input string what, input rsp_t want, input rsp_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: expected value %h depth %0d status %0d, got value %h depth %0d status %0d",
               $realtime, what, want.result_value, want.final_depth, want.status,
               got.result_value, got.final_depth, got.status);
  endfunction

  always @(posedge clk) begin : check_responses
    rsp_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_ready) begin
      if (expected_results.size() == 0) begin
        note_mismatch("unexpected response", '0, rsp);
      end else begin
        want = expected_results.pop_front();
        if (rsp.result_value !== want.result_value) note_mismatch("result_value", want, rsp);
        if (rsp.final_depth !== want.final_depth) note_mismatch("final_depth", want, rsp);
        if (rsp.status !== want.status) note_mismatch("status", want, rsp);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_empty_stack();
    send_request(ACT_STOP, 32'h0);
    send_request(ACT_PRINT, 32'hffff_ffff);
    send_request(ACT_ADD, 32'h0);
  endtask

  task automatic test_wraparound();
    send_request(ACT_PUSH, 32'h7fff_ffff);
    send_request(ACT_MUL, 32'h0);
    send_request(ACT_PUSH, 32'h1);
    send_request(ACT_ADD, 32'h0);
    send_request(ACT_PUSH, 32'h1);
    send_request(ACT_SUB, 32'h0);
    send_request(ACT_PUSH, 32'h7fff_ffff);
    send_request(ACT_MUL, 32'h0);
    send_request(ACT_PRINT, 32'h0);
  endtask

  task automatic test_min_over_minus_one();
    send_request(ACT_PUSH, 32'h8000_0000);
    send_request(ACT_PUSH, 32'hffff_ffff);
    send_request(ACT_DIV, 32'h0);
    send_request(ACT_PRINT, 32'h0);
    send_request(ACT_PUSH, 32'h8000_0000);
    send_request(ACT_PUSH, 32'hffff_ffff);
    send_request(ACT_MOD, 32'h0);
    send_request(ACT_PRINT, 32'h0);
  endtask

  task automatic test_divide_by_zero();
    send_request(ACT_PUSH, 32'hffff_fff9);
    send_request(ACT_PUSH, 32'h0);
    send_request(ACT_DIV, 32'h0);
    send_request(ACT_MOD, 32'h0);
    send_request(ACT_STOP, 32'h0);
  endtask

  task automatic test_stack_overflow();
    repeat (STACK_SLOTS) send_request(ACT_PUSH, $urandom);
    send_request(ACT_PUSH, 32'h1234_5678);
    send_request(ACT_PRINT, 32'h0);
    send_request(ACT_PUSH, $urandom);
    send_request(ACT_PUSH, $urandom);
    send_request(ACT_STOP, 32'h0);
  endtask

  // Long receiver hold while responses pile up and the input stalls.
  task automatic test_backpressure();
    hold_request = 1'b1;
    repeat (3) send_request(ACT_PUSH, $urandom);
    repeat (12) send_request(ACT_PRINT, 32'h0);
    send_request(ACT_STOP, 32'h0);
  endtask

  // Mostly well-formed programs with random content, some noise and fill bursts.
  task automatic test_random_programs();
    action_t act;
    int roll;
    int fill_left;
    fill_left = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 120 == 0) begin
        send_idle = $urandom_range(0, 3) != 0;
        recv_idle = $urandom_range(0, 3) != 0;
      end
      if (fill_left == 0 && $urandom_range(0, 299) == 0)
        fill_left = 70;
      roll = $urandom_range(0, 99);
      if (fill_left > 0) begin
        act = ACT_PUSH;
        fill_left--;
      end else if (roll < 8) begin
        act = action_t'($urandom_range(0, 7));
      end else if (eval_depth < 2) begin
        act = ACT_PUSH;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 35) act = ACT_PUSH;
        else if (roll < 85) act = action_t'($urandom_range(ACT_ADD, ACT_MOD));
        else if (roll < 96) act = ACT_PRINT;
        else act = ACT_STOP;
      end
      send_request(act, pick_operand());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_stack();
    test_wraparound();
    test_min_over_minus_one();
    test_divide_by_zero();
    test_stack_overflow();
    test_backpressure();
    test_random_programs();
    cmd_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
